// ===== sv/krt_pkg.sv =====
// Package for the keyed record table: field widths, request codes and the
// structs that move between the table cells and the controller.
// No dependencies.
package krt_pkg;

  localparam int unsigned KEY_W     = 32;
  localparam int unsigned PAYLOAD_W = 64;
  localparam int unsigned SLOT_W    = 6;
  localparam int unsigned COUNT_W   = 7;

  typedef enum logic [1:0] {
    REQ_APPEND = 2'd0,
    REQ_DELETE = 2'd1,
    REQ_FIND   = 2'd2,
    REQ_CLEAR  = 2'd3
  } req_e;

  // Search token that travels down the row of cells, one cell per cycle.
  typedef struct packed {
    logic                 act;
    logic                 found;
    logic [SLOT_W-1:0]    slot;
    logic [PAYLOAD_W-1:0] payload;
  } tok_t;

  typedef struct packed {
    logic                 success;
    logic [SLOT_W-1:0]    slot;
    logic [PAYLOAD_W-1:0] found_payload;
    logic [COUNT_W-1:0]   entry_count;
  } rsp_t;

  function automatic logic [COUNT_W-1:0] count_field(input logic [31:0] cnt);
    return cnt[COUNT_W-1:0];
  endfunction

endpackage

// ===== sv/krt_ifs.sv =====
// Valid/ready channel interfaces for the keyed record table: requests in and
// responses out. Depends on krt_pkg.
interface krt_req_if import krt_pkg::*; ();
  logic                 valid;
  logic                 ready;
  logic [1:0]           req_type;
  logic signed [KEY_W-1:0] key;
  logic [PAYLOAD_W-1:0] payload;

  modport source (output valid, output req_type, output key, output payload, input ready);
  modport sink   (input valid, input req_type, input key, input payload, output ready);
endinterface

interface krt_rsp_if import krt_pkg::*; ();
  logic                 valid;
  logic                 ready;
  logic                 success;
  logic [SLOT_W-1:0]    slot;
  logic [PAYLOAD_W-1:0] found_payload;
  logic [COUNT_W-1:0]   entry_count;

  modport source (output valid, output success, output slot, output found_payload,
                  output entry_count, input ready);
  modport sink   (input valid, input success, input slot, input found_payload,
                  input entry_count, output ready);
endinterface

// ===== sv/krt_cell.sv =====
// One cell of the record row: holds one key and payload, matches the passing
// search token and shifts in its right neighbor on delete. Depends on krt_pkg.
module krt_cell import krt_pkg::*; #(
  parameter int unsigned IDX   = 0,
  parameter int unsigned CNT_W = 7
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 wr_en_i,
  input  logic [KEY_W-1:0]     wr_key_i,
  input  logic [PAYLOAD_W-1:0] wr_payload_i,
  input  logic                 del_i,
  input  logic [KEY_W-1:0]     srch_key_i,
  input  logic [CNT_W-1:0]     count_i,
  input  tok_t                 tok_i,
  output tok_t                 tok_o,
  input  logic [KEY_W-1:0]     nbr_key_i,
  input  logic [PAYLOAD_W-1:0] nbr_payload_i,
  output logic [KEY_W-1:0]     key_o,
  output logic [PAYLOAD_W-1:0] payload_o
);

  logic [KEY_W-1:0]     key_q;
  logic [PAYLOAD_W-1:0] payload_q;
  tok_t                 tok_q;
  tok_t                 tok_d;
  logic                 live;
  logic                 match;
  logic                 hit;

  assign live  = CNT_W'(IDX) < count_i;
  assign match = tok_i.act & live & (key_q == srch_key_i);
  assign hit   = match & ~tok_i.found;

  always_comb begin
    tok_d       = tok_i;
    tok_d.found = tok_i.found | match;
    if (hit) begin
      tok_d.slot    = SLOT_W'(IDX);
      tok_d.payload = payload_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      tok_q <= '0;
    end else begin
      tok_q <= tok_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (wr_en_i && (CNT_W'(IDX) == count_i)) begin
      key_q     <= wr_key_i;
      payload_q <= wr_payload_i;
    end else if (del_i && tok_i.act && (tok_i.found || match)) begin
      key_q     <= nbr_key_i;
      payload_q <= nbr_payload_i;
    end
  end

  assign tok_o     = tok_q;
  assign key_o     = key_q;
  assign payload_o = payload_q;

endmodule

// ===== sv/keyed_record_table.sv =====
// Keyed record table top level: a row of MAX_ENTRIES cells kept in insertion
// order plus the request controller. Depends on krt_pkg, krt_ifs and krt_cell.
//
// The table takes one request at a time. Append and clear write their result
// into the result register, from which it moves to the response register.
// Delete and find send a search token down the row of cells, one cell per
// cycle, and the last cell's token is captured into the result register and
// then the response register. Delete closes the gap as the token passes, the
// matching cell and each later cell taking its right neighbor's record. A new
// request is taken as soon as the previous response is registered, even while
// that response is still waiting to be taken.
module keyed_record_table import krt_pkg::*; #(
  parameter int unsigned MAX_ENTRIES = 64
) (
  input  logic  clk_i,
  input  logic  rst_ni,
  krt_req_if.sink   req_i,
  krt_rsp_if.source rsp_o
);

  localparam int unsigned CNT_W = $clog2(MAX_ENTRIES + 1);

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_WAVE,
    ST_FIN
  } state_e;

  state_e             state_q;
  logic [CNT_W-1:0]   count_q;
  logic               start_q;
  logic               del_q;
  logic               find_q;
  logic [KEY_W-1:0]   key_q;
  rsp_t               res_q;
  rsp_t               out_q;
  logic               out_valid_q;

  logic               accept;
  logic               not_full;
  logic               wr_en;
  logic               load_out;
  rsp_t               wave_res;
  tok_t               tok_head;
  tok_t               tok_w [MAX_ENTRIES];
  logic [KEY_W-1:0]   key_w [MAX_ENTRIES];
  logic [PAYLOAD_W-1:0] pay_w [MAX_ENTRIES];

  assign req_i.ready = (state_q == ST_IDLE);
  assign accept      = req_i.valid & req_i.ready;
  assign not_full    = count_q < CNT_W'(MAX_ENTRIES);
  assign wr_en       = accept & (req_e'(req_i.req_type) == REQ_APPEND) & not_full;
  assign load_out    = (state_q == ST_FIN) & (~out_valid_q | rsp_o.ready);

  always_comb begin
    tok_head     = '0;
    tok_head.act = start_q;
  end

  always_comb begin
    wave_res             = '0;
    wave_res.success     = tok_w[MAX_ENTRIES-1].found;
    wave_res.entry_count = count_field(32'(count_q));
    if (tok_w[MAX_ENTRIES-1].found && del_q) begin
      wave_res.entry_count = count_field(32'(count_q) - 32'd1);
    end
    if (tok_w[MAX_ENTRIES-1].found && find_q) begin
      wave_res.slot          = tok_w[MAX_ENTRIES-1].slot;
      wave_res.found_payload = tok_w[MAX_ENTRIES-1].payload;
    end
  end

  for (genvar i = 0; i < MAX_ENTRIES; i++) begin : g_cell
    tok_t                 tok_in;
    logic [KEY_W-1:0]     nbr_key;
    logic [PAYLOAD_W-1:0] nbr_pay;

    if (i == 0) begin : g_first
      assign tok_in = tok_head;
    end else begin : g_rest
      assign tok_in = tok_w[i-1];
    end

    if (i == MAX_ENTRIES - 1) begin : g_last
      assign nbr_key = '0;
      assign nbr_pay = '0;
    end else begin : g_inner
      assign nbr_key = key_w[i+1];
      assign nbr_pay = pay_w[i+1];
    end

    krt_cell #(
      .IDX   (i),
      .CNT_W (CNT_W)
    ) u_cell (
      .clk_i         (clk_i),
      .rst_ni        (rst_ni),
      .wr_en_i       (wr_en),
      .wr_key_i      (req_i.key),
      .wr_payload_i  (req_i.payload),
      .del_i         (del_q),
      .srch_key_i    (key_q),
      .count_i       (count_q),
      .tok_i         (tok_in),
      .tok_o         (tok_w[i]),
      .nbr_key_i     (nbr_key),
      .nbr_payload_i (nbr_pay),
      .key_o         (key_w[i]),
      .payload_o     (pay_w[i])
    );
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      count_q     <= '0;
      start_q     <= 1'b0;
      del_q       <= 1'b0;
      find_q      <= 1'b0;
      key_q       <= '0;
      res_q       <= '0;
      out_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (load_out) begin
        out_q       <= res_q;
        out_valid_q <= 1'b1;
      end else if (rsp_o.ready) begin
        out_valid_q <= 1'b0;
      end
      unique case (state_q)
        ST_IDLE: begin
          if (accept) begin
            unique case (req_e'(req_i.req_type))
              REQ_APPEND: begin
                if (not_full) begin
                  count_q <= count_q + CNT_W'(1);
                  res_q   <= '{success: 1'b1, slot: '0, found_payload: '0,
                               entry_count: count_field(32'(count_q) + 32'd1)};
                end else begin
                  res_q   <= '{success: 1'b0, slot: '0, found_payload: '0,
                               entry_count: count_field(32'(count_q))};
                end
                state_q <= ST_FIN;
              end
              REQ_CLEAR: begin
                count_q <= '0;
                res_q   <= '{success: 1'b1, slot: '0, found_payload: '0,
                             entry_count: '0};
                state_q <= ST_FIN;
              end
              REQ_DELETE, REQ_FIND: begin
                key_q   <= req_i.key;
                del_q   <= (req_e'(req_i.req_type) == REQ_DELETE);
                find_q  <= (req_e'(req_i.req_type) == REQ_FIND);
                start_q <= 1'b1;
                state_q <= ST_WAVE;
              end
            endcase
          end
        end
        ST_WAVE: begin
          start_q <= 1'b0;
          if (tok_w[MAX_ENTRIES-1].act) begin
            res_q <= wave_res;
            if (tok_w[MAX_ENTRIES-1].found && del_q) begin
              count_q <= count_q - CNT_W'(1);
            end
            del_q   <= 1'b0;
            find_q  <= 1'b0;
            state_q <= ST_FIN;
          end
        end
        ST_FIN: begin
          if (load_out) begin
            state_q <= ST_IDLE;
          end
        end
        default: begin
          state_q <= ST_IDLE;
        end
      endcase
    end
  end

  assign rsp_o.valid         = out_valid_q;
  assign rsp_o.success       = out_q.success;
  assign rsp_o.slot          = out_q.slot;
  assign rsp_o.found_payload = out_q.found_payload;
  assign rsp_o.entry_count   = out_q.entry_count;

  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= CNT_W'(MAX_ENTRIES))
    else $error("Record count exceeds the table size.");

  a_tail_in_wave: assert property (@(posedge clk_i) disable iff (!rst_ni)
    tok_w[MAX_ENTRIES-1].act |-> state_q == ST_WAVE)
    else $error("Search token reached the end of the row outside a search.");

  a_accept_leaves_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (req_i.valid && req_i.ready) |=> state_q != ST_IDLE)
    else $error("Accepted request transaction did not start work.");

  a_rsp_from_fin: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_q) |-> $past(state_q) == ST_FIN)
    else $error("Response raised without a finished request.");

endmodule

// ===== verif/tb_keyed_record_table.sv =====
// Self-checking testbench for the keyed record table: random and directed
// append, delete, find and clear transactions checked against a predictor.
// Depends on krt_pkg, krt_ifs and keyed_record_table.
module tb_keyed_record_table import krt_pkg::*; ();

  localparam int unsigned TABLE_DEPTH = 64;
  localparam int unsigned ITEM_TOTAL  = 1500;
  localparam int unsigned CALM_AFTER  = 1350;
  localparam int unsigned LONG_HOLD   = 300;
  localparam int unsigned POOL_SIZE   = 16;

  typedef enum int {MIX_FILL, MIX_GROW, MIX_SHRINK, MIX_EVEN} mix_e;

  class record_table_tracker #(int unsigned DEPTH = 64);
    logic [KEY_W-1:0]     key_mem [DEPTH];
    logic [PAYLOAD_W-1:0] payload_mem [DEPTH];
    int unsigned          fill;
    rsp_t                 pending_rsp [$];
    int unsigned          mismatches;

    function new();
      fill       = 0;
      mismatches = 0;
    endfunction

    function logic [KEY_W-1:0] live_key();
      return key_mem[$urandom_range(0, fill - 1)];
    endfunction

    function void note_request(req_e op, logic [KEY_W-1:0] k, logic [PAYLOAD_W-1:0] p);
      rsp_t want;
      int   hit;
      want = '0;
      hit  = -1;
      if (op == REQ_DELETE || op == REQ_FIND) begin
        for (int i = 0; i < int'(fill); i++) begin
          if (key_mem[i] == k) begin
            hit = i;
            break;
          end
        end
      end
      case (op)
        REQ_APPEND: begin
          if (fill < DEPTH) begin
            key_mem[fill]     = k;
            payload_mem[fill] = p;
            fill++;
            want.success = 1'b1;
          end
        end
        REQ_DELETE: begin
          if (hit >= 0) begin
            for (int j = hit; j + 1 < int'(fill); j++) begin
              key_mem[j]     = key_mem[j + 1];
              payload_mem[j] = payload_mem[j + 1];
            end
            fill--;
            want.success = 1'b1;
          end
        end
        REQ_FIND: begin
          if (hit >= 0) begin
            want.success       = 1'b1;
            want.slot          = SLOT_W'(hit);
            want.found_payload = payload_mem[hit];
          end
        end
        default: begin
          fill         = 0;
          want.success = 1'b1;
        end
      endcase
      want.entry_count = COUNT_W'(fill);
      pending_rsp.push_back(want);
    endfunction

    function void check_response(rsp_t got);
      rsp_t want;
      if (pending_rsp.size() == 0) begin
        $error("Response transaction arrived with no request outstanding.");
        mismatches++;
        return;
      end
      want = pending_rsp.pop_front();
      if (got.success !== want.success) begin
        $error("success: expected %0d, actual %0d", want.success, got.success);
        mismatches++;
      end
      if (got.slot !== want.slot) begin
        $error("slot: expected %0d, actual %0d", want.slot, got.slot);
        mismatches++;
      end
      if (got.found_payload !== want.found_payload) begin
        $error("found_payload: expected %h, actual %h", want.found_payload,
               got.found_payload);
        mismatches++;
      end
      if (got.entry_count !== want.entry_count) begin
        $error("entry_count: expected %0d, actual %0d", want.entry_count,
               got.entry_count);
        mismatches++;
      end
    endfunction
  endclass

  logic clk = 1'b0;
  logic rst_n;

  krt_req_if req_ch ();
  krt_rsp_if rsp_ch ();

  keyed_record_table #(.MAX_ENTRIES(TABLE_DEPTH)) uut (
    .clk_i  (clk),
    .rst_ni (rst_n),
    .req_i  (req_ch),
    .rsp_o  (rsp_ch)
  );

  record_table_tracker #(TABLE_DEPTH) tracker;

  logic [KEY_W-1:0] key_pool [POOL_SIZE];
  int unsigned      sent;
  bit               calm;
  bit               tx_idle_on;
  bit               rx_idle_on;
  bit               long_hold_req;

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  initial begin
    #8_000_000;
    $display("Testbench completed WITH ERRORS");
    $finish;
  end

  always @(posedge clk) begin
    if (rst_n && rsp_ch.valid && rsp_ch.ready) begin
      tracker.check_response({rsp_ch.success, rsp_ch.slot, rsp_ch.found_payload,
                              rsp_ch.entry_count});
    end
  end

  initial begin
    rsp_ch.ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (long_hold_req) begin
        long_hold_req = 1'b0;
        rsp_ch.ready <= 1'b0;
        repeat (LONG_HOLD) @(posedge clk);
        rsp_ch.ready <= 1'b1;
      end else if (!calm && rx_idle_on && $urandom_range(0, 4) == 0) begin
        rsp_ch.ready <= 1'b0;
        repeat ($urandom_range(1, 3)) @(posedge clk);
        rsp_ch.ready <= 1'b1;
      end else begin
        rsp_ch.ready <= 1'b1;
      end
    end
  end

  task automatic send_request(req_e op, logic [KEY_W-1:0] k, logic [PAYLOAD_W-1:0] p);
    req_ch.valid    <= 1'b1;
    req_ch.req_type <= op;
    req_ch.key      <= k;
    req_ch.payload  <= p;
    @(posedge clk);
    while (!req_ch.ready) @(posedge clk);
    tracker.note_request(op, k, p);
    sent++;
    if (!calm && tx_idle_on && $urandom_range(0, 3) == 0) begin
      req_ch.valid <= 1'b0;
      repeat ($urandom_range(1, 3)) @(posedge clk);
    end
  endtask

  task automatic wait_for_responses(int unsigned guard);
    int unsigned waited;
    waited = 0;
    req_ch.valid <= 1'b0;
    while (tracker.pending_rsp.size() != 0 && waited < guard) begin
      @(posedge clk);
      waited++;
    end
  endtask

  function automatic logic [PAYLOAD_W-1:0] pick_payload();
    int unsigned roll;
    roll = $urandom_range(0, 19);
    if (roll == 0) return '1;
    if (roll == 1) return '0;
    return {$urandom, $urandom};
  endfunction

  function automatic logic [KEY_W-1:0] pick_key(req_e op);
    int unsigned roll;
    roll = $urandom_range(0, 99);
    if (op == REQ_APPEND) begin
      return (roll < 50) ? key_pool[$urandom_range(0, POOL_SIZE - 1)] : KEY_W'($urandom);
    end
    if (roll < 60 && tracker.fill > 0) return tracker.live_key();
    if (roll < 85) return key_pool[$urandom_range(0, POOL_SIZE - 1)];
    return KEY_W'($urandom);
  endfunction

  function automatic req_e pick_op(mix_e mix);
    int unsigned roll;
    int unsigned add_pct;
    int unsigned del_pct;
    int unsigned find_pct;
    roll = $urandom_range(0, 99);
    case (mix)
      MIX_FILL:   begin add_pct = 90; del_pct = 0;  find_pct = 10; end
      MIX_GROW:   begin add_pct = 55; del_pct = 15; find_pct = 28; end
      MIX_SHRINK: begin add_pct = 15; del_pct = 55; find_pct = 28; end
      default:    begin add_pct = 35; del_pct = 30; find_pct = 33; end
    endcase
    if (roll < add_pct) return REQ_APPEND;
    if (roll < add_pct + del_pct) return REQ_DELETE;
    if (roll < add_pct + del_pct + find_pct) return REQ_FIND;
    return REQ_CLEAR;
  endfunction

  initial begin
    int unsigned phase;
    int unsigned run_len;
    mix_e        mix;
    req_e        op;

    tracker         = new();
    sent            = 0;
    calm            = 1'b0;
    tx_idle_on      = 1'b1;
    rx_idle_on      = 1'b1;
    long_hold_req   = 1'b0;
    rst_n           <= 1'b0;
    req_ch.valid    <= 1'b0;
    req_ch.req_type <= REQ_APPEND;
    req_ch.key      <= '0;
    req_ch.payload  <= '0;

    key_pool[0] = 32'h8000_0000;
    key_pool[1] = 32'h7fff_ffff;
    key_pool[2] = 32'h0000_0000;
    key_pool[3] = 32'hffff_ffff;
    key_pool[4] = 32'h0000_0001;
    for (int i = 5; i < int'(POOL_SIZE); i++) key_pool[i] = $urandom;

    repeat (2) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Empty-table misses, clear on an empty table, duplicates and the
    // compaction that follows a delete.
    send_request(REQ_FIND, 32'h0000_0000, pick_payload());
    send_request(REQ_DELETE, 32'h7fff_ffff, pick_payload());
    send_request(REQ_CLEAR, 32'h0000_0000, pick_payload());
    send_request(REQ_APPEND, 32'h8000_0000, 64'h0);
    send_request(REQ_APPEND, 32'h7fff_ffff, '1);
    send_request(REQ_APPEND, 32'hffff_ffff, 64'h8000_0000_0000_0000);
    send_request(REQ_APPEND, 32'h7fff_ffff, 64'h1);
    send_request(REQ_FIND, 32'h7fff_ffff, pick_payload());
    send_request(REQ_FIND, 32'h8000_0000, pick_payload());
    send_request(REQ_FIND, 32'h1234_5678, pick_payload());
    send_request(REQ_DELETE, 32'h7fff_ffff, pick_payload());
    send_request(REQ_FIND, 32'h7fff_ffff, pick_payload());
    send_request(REQ_DELETE, 32'h55aa_55aa, pick_payload());
    send_request(REQ_DELETE, 32'h8000_0000, pick_payload());
    send_request(REQ_FIND, 32'hffff_ffff, pick_payload());
    send_request(REQ_CLEAR, 32'hffff_ffff, pick_payload());
    send_request(REQ_CLEAR, 32'h0000_0000, pick_payload());
    send_request(REQ_FIND, 32'hffff_ffff, pick_payload());

    phase = 0;
    while (sent < ITEM_TOTAL) begin
      if (phase == 1 || phase == 6) begin
        mix = MIX_FILL;
      end else begin
        mix = mix_e'($urandom_range(0, 3));
      end
      run_len    = (mix == MIX_FILL) ? 100 : $urandom_range(40, 120);
      tx_idle_on = ($urandom_range(0, 3) != 0);
      rx_idle_on = ($urandom_range(0, 3) != 0);
      if (phase == 2) begin
        long_hold_req = 1'b1;
      end
      if (phase == 3 || (phase != 2 && $urandom_range(0, 5) == 0)) begin
        wait_for_responses(10_000);
      end
      for (int n = 0; n < int'(run_len) && sent < ITEM_TOTAL; n++) begin
        if (sent >= CALM_AFTER) calm = 1'b1;
        op = pick_op(mix);
        send_request(op, pick_key(op), pick_payload());
      end
      phase++;
    end

    wait_for_responses(20_000);
    repeat (2 * TABLE_DEPTH) @(posedge clk);
    if (tracker.pending_rsp.size() != 0) begin
      $error("%0d expected responses never arrived.", tracker.pending_rsp.size());
      tracker.mismatches++;
    end
    if (tracker.mismatches == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule

// ===== keyed_record_table.f =====
sv/krt_pkg.sv
sv/krt_ifs.sv
sv/krt_cell.sv
sv/keyed_record_table.sv
verif/tb_keyed_record_table.sv
